### rtl/line_start_message_id_detector_assert.svh
// Assertion macros shared by the message identifier detector.
`ifndef LINE_START_MESSAGE_ID_DETECTOR_ASSERT_SVH
`define LINE_START_MESSAGE_ID_DETECTOR_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define LSMID_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lsmid: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define LSMID_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lsmid: next-cycle check failed");

`endif

### rtl/lsmid_pkg.sv
package lsmid_pkg;

  // One input beat: a text byte or the end-of-text marker.
  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_beat_t;

  // One result beat: the decision for a line.
  typedef struct packed {
    logic       accepted;
    logic [5:0] id_length;
    logic [7:0] lead_offset;
    logic [7:0] final_char;
  } out_beat_t;

  // Scan phase within a line.
  typedef enum logic [2:0] {
    PH_LEAD,
    PH_PREFIX,
    PH_SUFFIX,
    PH_DIGITS,
    PH_SEV
  } phase_t;

  // Character codes.
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_AT     = 8'h40;
  localparam logic [7:0] CH_US     = 8'h5F;
  localparam logic [7:0] CH_UP_LO  = 8'h41;
  localparam logic [7:0] CH_UP_HI  = 8'h5A;
  localparam logic [7:0] CH_DIG_LO = 8'h30;
  localparam logic [7:0] CH_DIG_HI = 8'h39;
  localparam logic [7:0] CH_SEV_I  = 8'h49;
  localparam logic [7:0] CH_SEV_E  = 8'h45;
  localparam logic [7:0] CH_SEV_W  = 8'h57;
  localparam logic [7:0] CH_SEV_A  = 8'h41;
  localparam logic [7:0] CH_SEV_S  = 8'h53;
  localparam logic [7:0] CH_SEV_D  = 8'h44;
  localparam logic [7:0] CH_SEV_X  = 8'h58;

  // Limits of the identifier grammar.
  localparam logic [3:0] PREFIX_MIN  = 4'd2;
  localparam logic [3:0] PREFIX_MAX  = 4'd8;
  localparam logic [2:0] DIGIT_MAX   = 3'd5;
  localparam logic [5:0] SUFFIX_MIN  = 6'd2;
  localparam logic [5:0] SUFFIX_SAT  = 6'd63;
  localparam logic [7:0] SPACE_SAT   = 8'd255;
  localparam logic [6:0] ID_LEN_SAT  = 7'd63;

endpackage

### rtl/lsmid_stream_if.sv
interface lsmid_stream_if #(
  parameter type beat_t = logic
);
  logic  valid;
  logic  ready;
  beat_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### rtl/lsmid_pipe_reg.sv
module lsmid_pipe_reg #(
  parameter type beat_t = logic
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  s_valid,
  output logic  s_ready,
  input  beat_t s_data,
  output logic  m_valid,
  input  logic  m_ready,
  output beat_t m_data
);

  logic  valid_r;
  beat_t data_r;

  // The stage takes a new beat when empty or when its beat leaves this cycle.
  assign s_ready = !valid_r || m_ready;
  assign m_valid = valid_r;
  assign m_data  = data_r;

  // Valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (s_ready) begin
      valid_r <= s_valid;
    end
  end

  // Payload holds while stalled.
  always_ff @(posedge clk) begin
    if (s_ready && s_valid) begin
      data_r <= s_data;
    end
  end

endmodule

### rtl/lsmid_scanner.sv
module lsmid_scanner
  import lsmid_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      beat_valid,
  output logic      beat_ready,
  input  in_beat_t  beat,
  output logic      res_valid,
  input  logic      res_ready,
  output out_beat_t res
);

  phase_t     phase_r,  phase_nxt;
  logic       decided_r, decided_nxt;
  logic [3:0] prefix_r, prefix_nxt;
  logic [2:0] digit_r,  digit_nxt;
  logic [5:0] suffix_r, suffix_nxt;
  logic [7:0] space_r,  space_nxt;
  logic [7:0] last_r,   last_nxt;

  logic       fire;
  logic [7:0] c;
  logic       eot;
  logic       is_nl, is_ws, is_up, is_dig, is_us, is_pre, is_sev;
  logic       line_end;
  phase_t     eff_phase;
  logic       emit;
  logic       ok;
  logic [6:0] len;
  logic [6:0] len_sat;

  // A beat is consumed whenever the result stage can take a result.
  assign beat_ready = res_ready;
  assign fire       = beat_valid && res_ready;
  assign c          = beat.text_byte;
  assign eot        = beat.end_of_text;

  // Character classes.
  assign is_nl  = (c == CH_NL);
  assign is_ws  = (c == CH_SPACE) || (c == CH_TAB);
  assign is_up  = (c >= CH_UP_LO) && (c <= CH_UP_HI);
  assign is_dig = (c >= CH_DIG_LO) && (c <= CH_DIG_HI);
  assign is_us  = (c == CH_US);
  assign is_pre = is_up || (c == CH_DOLLAR) || (c == CH_HASH) || (c == CH_AT);
  assign is_sev = (c == CH_SEV_I) || (c == CH_SEV_E) || (c == CH_SEV_W) ||
                  (c == CH_SEV_A) || (c == CH_SEV_S) || (c == CH_SEV_D) ||
                  (c == CH_SEV_X);

  assign line_end = eot || is_nl;

  // The first non-blank character is handled as a prefix character.
  assign eff_phase = ((phase_r == PH_LEAD) && !is_ws) ? PH_PREFIX : phase_r;

  // Next state of the line scan.
  always_comb begin
    phase_nxt   = phase_r;
    decided_nxt = decided_r;
    prefix_nxt  = prefix_r;
    digit_nxt   = digit_r;
    suffix_nxt  = suffix_r;
    space_nxt   = space_r;
    last_nxt    = last_r;
    if (fire) begin
      if (line_end) begin
        phase_nxt   = PH_LEAD;
        decided_nxt = 1'b0;
        prefix_nxt  = '0;
        digit_nxt   = '0;
        suffix_nxt  = '0;
        space_nxt   = '0;
        last_nxt    = '0;
      end else if (!decided_r) begin
        decided_nxt = emit;
        if ((phase_r == PH_LEAD) && is_ws) begin
          if (space_r != SPACE_SAT) begin
            space_nxt = space_r + 8'd1;
          end
        end else begin
          unique case (eff_phase)
            PH_PREFIX: begin
              phase_nxt = PH_PREFIX;
              if (is_pre) begin
                prefix_nxt = prefix_r + 4'd1;
                last_nxt   = c;
              end else if (prefix_r >= PREFIX_MIN) begin
                if (is_us) begin
                  phase_nxt = PH_SUFFIX;
                  last_nxt  = c;
                end else begin
                  phase_nxt = PH_DIGITS;
                  digit_nxt = is_dig ? 3'd1 : 3'd0;
                  if (is_dig) begin
                    last_nxt = c;
                  end
                end
              end
            end
            PH_DIGITS: begin
              if (is_dig) begin
                digit_nxt = digit_r + 3'd1;
                last_nxt  = c;
              end else if ((digit_r != 3'd0) && is_sev) begin
                phase_nxt = PH_SEV;
                last_nxt  = c;
              end
            end
            PH_SUFFIX: begin
              if (is_up || is_dig || is_us) begin
                if (suffix_r != SUFFIX_SAT) begin
                  suffix_nxt = suffix_r + 6'd1;
                end
                last_nxt = c;
              end
            end
            PH_SEV: begin
              phase_nxt = phase_r;
            end
            default: begin
              phase_nxt = phase_r;
            end
          endcase
        end
      end
    end
  end

  // Decision for the current beat: whether a result is due and its content.
  always_comb begin
    emit = 1'b0;
    ok   = 1'b0;
    len  = '0;
    if (line_end) begin
      if (eot) begin
        emit = !decided_r && !((phase_r == PH_LEAD) && (space_r == 8'd0));
      end else begin
        emit = !decided_r;
      end
      unique case (phase_r)
        PH_SUFFIX: begin
          ok  = (suffix_r >= SUFFIX_MIN);
          len = {3'd0, prefix_r} + 7'd1 + {1'b0, suffix_r};
        end
        PH_DIGITS: begin
          ok  = (digit_r != 3'd0);
          len = {3'd0, prefix_r} + {4'd0, digit_r};
        end
        PH_SEV: begin
          ok  = 1'b1;
          len = {3'd0, prefix_r} + {4'd0, digit_r} + 7'd1;
        end
        default: begin
          ok = 1'b0;
        end
      endcase
    end else if (!decided_r && !((phase_r == PH_LEAD) && is_ws)) begin
      unique case (eff_phase)
        PH_PREFIX: begin
          if (is_pre) begin
            emit = (prefix_r >= PREFIX_MAX);
          end else if (prefix_r < PREFIX_MIN) begin
            emit = 1'b1;
          end else begin
            emit = !is_us && !is_dig;
          end
        end
        PH_DIGITS: begin
          if (is_dig) begin
            emit = (digit_r >= DIGIT_MAX);
          end else if (digit_r == 3'd0) begin
            emit = 1'b1;
          end else if (!is_sev) begin
            emit = 1'b1;
            ok   = is_ws;
            len  = {3'd0, prefix_r} + {4'd0, digit_r};
          end
        end
        PH_SUFFIX: begin
          if (!(is_up || is_dig || is_us)) begin
            emit = 1'b1;
            ok   = is_ws && (suffix_r >= SUFFIX_MIN);
            len  = {3'd0, prefix_r} + 7'd1 + {1'b0, suffix_r};
          end
        end
        PH_SEV: begin
          emit = 1'b1;
          ok   = is_ws;
          len  = {3'd0, prefix_r} + {4'd0, digit_r} + 7'd1;
        end
        default: begin
          emit = 1'b1;
        end
      endcase
    end
  end

  // Result beat.
  assign len_sat         = (len > ID_LEN_SAT) ? ID_LEN_SAT : len;
  assign res_valid       = fire && emit;
  assign res.accepted    = ok;
  assign res.id_length   = ok ? len_sat[5:0] : 6'd0;
  assign res.lead_offset = space_r;
  assign res.final_char  = ok ? last_r : 8'd0;

  // Line state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_LEAD;
      decided_r <= 1'b0;
      prefix_r  <= '0;
      digit_r   <= '0;
      suffix_r  <= '0;
      space_r   <= '0;
      last_r    <= '0;
    end else begin
      phase_r   <= phase_nxt;
      decided_r <= decided_nxt;
      prefix_r  <= prefix_nxt;
      digit_r   <= digit_nxt;
      suffix_r  <= suffix_nxt;
      space_r   <= space_nxt;
      last_r    <= last_nxt;
    end
  end

endmodule

### rtl/line_start_message_id_detector.sv
// Line-start message identifier detector.
// The in_if channel carries one text beat per handshake: a byte, or an
// end-of-text marker that closes the current line. The out_if channel carries
// at most one result beat per line: accept or reject, identifier length,
// leading blank count and the identifier's last character.
// A result appears on the beat where the decision becomes certain: the blank
// after the identifier, the first character that breaks the grammar, or the
// line end. Later bytes of a decided line give nothing.
// A result passes from in_if through the input register, then the scan logic
// into the result register, and from there is valid on out_if.
// Throughput: one text beat per cycle, unless out_if stalls with a result held.
// Reset (rst_n low, synchronous) empties both registers and returns the scan
// to the start of a line.
// When out_if stalls, the result register holds; the input register keeps
// one further beat and in_if.ready then drops until the result is taken.
`include "line_start_message_id_detector_assert.svh"

module line_start_message_id_detector
  import lsmid_pkg::*;
(
  input logic            clk,
  input logic            rst_n,
  lsmid_stream_if.sink   in_if,
  lsmid_stream_if.source out_if
);

  logic      inb_valid;
  logic      inb_ready;
  in_beat_t  inb;
  logic      res_valid;
  logic      res_ready;
  out_beat_t res;

  logic       out_acc;
  logic       out_rej;
  logic [5:0] out_len;
  logic [7:0] out_last;
  logic       last_ok;

  // Input register.
  lsmid_pipe_reg #(.beat_t(in_beat_t)) u_in_reg (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (in_if.valid),
    .s_ready (in_if.ready),
    .s_data  (in_if.payload),
    .m_valid (inb_valid),
    .m_ready (inb_ready),
    .m_data  (inb)
  );

  // Line scan.
  lsmid_scanner u_scanner (
    .clk        (clk),
    .rst_n      (rst_n),
    .beat_valid (inb_valid),
    .beat_ready (inb_ready),
    .beat       (inb),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  // Result register.
  lsmid_pipe_reg #(.beat_t(out_beat_t)) u_out_reg (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (res_valid),
    .s_ready (res_ready),
    .s_data  (res),
    .m_valid (out_if.valid),
    .m_ready (out_if.ready),
    .m_data  (out_if.payload)
  );

  // Result fields seen by the checks below.
  assign out_acc  = out_if.valid && out_if.payload.accepted;
  assign out_rej  = out_if.valid && !out_if.payload.accepted;
  assign out_len  = out_if.payload.id_length;
  assign out_last = out_if.payload.final_char;
  assign last_ok  = ((out_last >= CH_DIG_LO) && (out_last <= CH_DIG_HI)) ||
                    ((out_last >= CH_UP_LO) && (out_last <= CH_UP_HI)) ||
                    (out_last == CH_US);

  // A rejected line carries no identifier length or character.
  `LSMID_ASSERT_NOW(a_reject_clean, out_rej, (out_len == 6'd0) && (out_last == 8'd0))
  // The shortest identifier is two prefix characters and one digit.
  `LSMID_ASSERT_NOW(a_accept_min_len, out_acc, out_len >= 6'd3)
  // An identifier ends in a digit, a letter or an underscore.
  `LSMID_ASSERT_NOW(a_accept_last_char, out_acc, last_ok)
  // A result from a consumed beat enters the output register and shows as valid on out_if.
  `LSMID_ASSERT_NEXT(a_res_from_beat, res_valid, out_if.valid)

endmodule
